@@ src/lpt_pkg.sv @@
package lpt_pkg;

	// Defaults for the top-level parameters
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SIG_DEPTH_DEF  = 256;

	// Fixed field widths
	localparam int DATA_W    = 32;
	localparam int TARGET_W  = 17;
	localparam int LR_W      = 31;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIAL_ID      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WEIGHT_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WEIGHT_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_BIAS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd4;

	// Sample queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	// One training sample as it travels through the queue
	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic [TARGET_W-1:0]      target;
		logic                     last;
	} sample_t;

	// Configuration as seen by the back end
	typedef struct packed {
		logic [DATA_W-1:0]        trial_id;
		logic signed [DATA_W-1:0] init_a;
		logic signed [DATA_W-1:0] init_b;
		logic signed [DATA_W-1:0] init_bias;
		logic [LR_W-1:0]          rate;
	} cfg_t;

endpackage

@@ src/lpt_front.sv @@
module lpt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  lpt_pkg::sample_t in_word,
	input  logic             take,
	output logic             avail,
	output lpt_pkg::sample_t out_word
);

	lpt_pkg::sample_t                mem_q [lpt_pkg::QUEUE_DEPTH];
	logic [lpt_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lpt_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lpt_pkg::QPTR_W:0]        count_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full     = (count_q == (lpt_pkg::QPTR_W+1)'(lpt_pkg::QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign out_word = mem_q[rd_ptr_q];
	assign do_wr    = push && !full;
	assign do_rd    = take && avail;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= in_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				if (wr_ptr_q == lpt_pkg::QPTR_W'(lpt_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_rd) begin
				if (rd_ptr_q == lpt_pkg::QPTR_W'(lpt_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/lpt_back.sv @@
module lpt_back #(
	parameter int FRAC_BITS           = lpt_pkg::FRAC_BITS_DEF,
	parameter int SIGMOID_TABLE_DEPTH = lpt_pkg::SIG_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lpt_pkg::cfg_t                     cfg,
	input  logic                              avail,
	input  lpt_pkg::sample_t                  in_word,
	output logic                              take,
	output logic                              empty,
	input  logic                              pop,
	output logic [lpt_pkg::DATA_W-1:0]        result_id,
	output logic signed [lpt_pkg::DATA_W-1:0] weight_a,
	output logic signed [lpt_pkg::DATA_W-1:0] weight_b,
	output logic signed [lpt_pkg::DATA_W-1:0] bias
);

	localparam int F     = FRAC_BITS;
	localparam int D     = SIGMOID_TABLE_DEPTH;
	localparam int OFF_W = F + 4;
	localparam int IDX_W = $clog2(D);
	localparam int DW    = $clog2(D + 1);
	localparam int ONE_W = F + 1;
	localparam int PW    = OFF_W + DW;

	localparam logic signed [33:0] OFF_BIAS = 34'sd1 <<< (F + 3);
	localparam logic signed [33:0] OFF_MAX  = (34'sd1 <<< (F + 4)) - 34'sd1;

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL1 = 4'd1;
	localparam logic [3:0] ST_Z    = 4'd2;
	localparam logic [3:0] ST_IDX  = 4'd3;
	localparam logic [3:0] ST_ROM  = 4'd4;
	localparam logic [3:0] ST_G1   = 4'd5;
	localparam logic [3:0] ST_G2   = 4'd6;
	localparam logic [3:0] ST_MUL2 = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;

	typedef logic [ONE_W-1:0] rom_t [D];

	// piecewise sigmoid at the centre of cell i
	function automatic logic [ONE_W-1:0] curve_at(input int i);
		longint one;
		longint x;
		longint t;
		longint y;
		one = longint'(1) <<< F;
		x = ((2 * longint'(i) + 1) * 8 * one) / D - 8 * one;
		t = (x < 0) ? -x : x;
		if (t >= 5 * one) begin
			y = one;
		end else if (t >= (19 * one) / 8) begin
			y = (t >>> 5) + (27 * one) / 32;
		end else if (t >= one) begin
			y = (t >>> 3) + (5 * one) / 8;
		end else begin
			y = (t >>> 2) + one / 2;
		end
		return ONE_W'((x < 0) ? one - y : y);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < D; i++) begin
			r[i] = curve_at(i);
		end
		return r;
	endfunction

	localparam rom_t SIG_ROM = build_rom();

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v[65:31] == {35{v[65]}}) begin
			return v[31:0];
		end else if (v[65]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7FFF_FFFF;
		end
	endfunction

	logic [3:0]                 state_q;
	logic                       started_q;
	logic signed [31:0]         wa_q;
	logic signed [31:0]         wb_q;
	logic signed [31:0]         bias_q;
	logic signed [31:0]         a_q;
	logic signed [31:0]         b_q;
	logic [lpt_pkg::TARGET_W-1:0] r_q;
	logic                       last_q;
	logic signed [63:0]         prod_a_q;
	logic signed [63:0]         prod_b_q;
	logic signed [31:0]         z_q;
	logic [IDX_W-1:0]           idx_q;
	logic [ONE_W-1:0]           rr_q;
	logic signed [31:0]         g_q;
	logic                       out_valid_q;
	logic [31:0]                res_id_q;
	logic signed [31:0]         res_wa_q;
	logic signed [31:0]         res_wb_q;
	logic signed [31:0]         res_bias_q;

	logic signed [31:0]         mul0_x;
	logic signed [31:0]         mul0_y;
	logic signed [31:0]         mul1_x;
	logic signed [31:0]         mul1_y;
	logic signed [63:0]         mul0;
	logic signed [63:0]         mul1;
	logic signed [31:0]         err;
	logic signed [31:0]         z_d;
	logic signed [33:0]         off_full;
	logic [OFF_W-1:0]           off;
	logic [PW-1:0]              idx_prod;
	logic signed [31:0]         g_d;
	logic signed [31:0]         nwa;
	logic signed [31:0]         nwb;
	logic signed [31:0]         nbias;
	logic                       emit_ok;

	assign take      = (state_q == ST_IDLE) && avail;
	assign empty     = !out_valid_q;
	assign result_id = res_id_q;
	assign weight_a  = res_wa_q;
	assign weight_b  = res_wb_q;
	assign bias      = res_bias_q;

	// error against the table output
	assign err = $signed(32'(r_q)) - $signed(32'(rr_q));

	// two shared multipliers, operands picked by step
	always_comb begin
		mul0_x = wa_q;
		mul0_y = a_q;
		mul1_x = wb_q;
		mul1_y = b_q;
		if (state_q == ST_G1) begin
			mul0_x = $signed({1'b0, cfg.rate});
			mul0_y = err;
		end else if (state_q == ST_MUL2) begin
			mul0_x = g_q;
			mul1_x = g_q;
		end
	end
	assign mul0 = mul0_x * mul0_y;
	assign mul1 = mul1_x * mul1_y;

	// weighted sum
	assign z_d = sat32(66'(prod_a_q >>> F) + 66'(prod_b_q >>> F) + 66'(bias_q));

	// clamp into the table span and pick the cell
	always_comb begin
		off_full = 34'(z_q) + OFF_BIAS;
		if (off_full < 34'sd0) begin
			off = '0;
		end else if (off_full > OFF_MAX) begin
			off = OFF_MAX[OFF_W-1:0];
		end else begin
			off = off_full[OFF_W-1:0];
		end
	end
	assign idx_prod = PW'(off) * PW'(D);

	// step size and weight updates
	assign g_d   = sat32(66'(prod_a_q >>> F));
	assign nwa   = sat32(66'(wa_q) + 66'(prod_a_q >>> F));
	assign nwb   = sat32(66'(wb_q) + 66'(prod_b_q >>> F));
	assign nbias = sat32(66'(bias_q) + 66'(g_q));

	assign emit_ok = !out_valid_q || pop;

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				if (avail) begin
					a_q    <= in_word.a;
					b_q    <= in_word.b;
					r_q    <= in_word.target;
					last_q <= in_word.last;
				end
			end
			ST_MUL1, ST_G1, ST_MUL2: begin
				prod_a_q <= mul0;
				prod_b_q <= mul1;
			end
			ST_Z:   z_q   <= z_d;
			ST_IDX: idx_q <= idx_prod[OFF_W +: IDX_W];
			ST_ROM: rr_q  <= SIG_ROM[idx_q];
			ST_G2:  g_q   <= g_d;
			default: ;
		endcase
		if (state_q == ST_UPD && last_q && emit_ok) begin
			res_id_q   <= cfg.trial_id;
			res_wa_q   <= nwa;
			res_wb_q   <= nwb;
			res_bias_q <= nbias;
		end
	end

	// sequencer, weights and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			wa_q        <= '0;
			wb_q        <= '0;
			bias_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new weight word replaces the one taken in the same cycle
			if (state_q == ST_UPD && last_q && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						if (!started_q) begin
							wa_q   <= cfg.init_a;
							wb_q   <= cfg.init_b;
							bias_q <= cfg.init_bias;
						end
						started_q <= 1'b1;
						state_q   <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_Z;
				ST_Z:    state_q <= ST_IDX;
				ST_IDX:  state_q <= ST_ROM;
				ST_ROM:  state_q <= ST_G1;
				ST_G1:   state_q <= ST_G2;
				ST_G2:   state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_UPD;
				ST_UPD: begin
					if (!last_q || emit_ok) begin
						wa_q    <= nwa;
						wb_q    <= nwb;
						bias_q  <= nbias;
						state_q <= ST_IDLE;
						if (last_q) begin
							started_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/logistic_perceptron_trainer.sv @@
// A sample marked last goes from the queue pop through MUL1, Z, IDX, ROM, G1, G2,
// MUL2 and UPD to its result word. The back end takes no new sample until the eight
// steps (two shared 32x32 multipliers, in three of them) end; UPD stalls on an unread word.
// A two-word sample queue takes input while the back end works.
// Reset (arst_n low) clears the queue, the sequencer, the weights and the result flag.
module logistic_perceptron_trainer #(
	parameter int FRAC_BITS           = lpt_pkg::FRAC_BITS_DEF,
	parameter int SIGMOID_TABLE_DEPTH = lpt_pkg::SIG_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [lpt_pkg::DATA_W-1:0]    sample_a,
	input  logic signed [lpt_pkg::DATA_W-1:0]    sample_b,
	input  logic [lpt_pkg::TARGET_W-1:0]         target,
	input  logic                                 last_sample,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [lpt_pkg::DATA_W-1:0]           result_id,
	output logic signed [lpt_pkg::DATA_W-1:0]    weight_a,
	output logic signed [lpt_pkg::DATA_W-1:0]    weight_b,
	output logic signed [lpt_pkg::DATA_W-1:0]    bias,
	input  logic                                 cfg_we,
	input  logic [lpt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lpt_pkg::DATA_W-1:0]           cfg_data
);

	localparam logic [lpt_pkg::LR_W-1:0] RATE_RESET = lpt_pkg::LR_W'(1) << FRAC_BITS;

	lpt_pkg::cfg_t    cfg_q;
	lpt_pkg::sample_t in_word;
	lpt_pkg::sample_t q_word;
	logic             q_avail;
	logic             q_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trial_id  <= '0;
			cfg_q.init_a    <= '0;
			cfg_q.init_b    <= '0;
			cfg_q.init_bias <= '0;
			cfg_q.rate      <= RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpt_pkg::REG_TRIAL_ID:      cfg_q.trial_id  <= cfg_data;
				lpt_pkg::REG_INIT_WEIGHT_A: cfg_q.init_a    <= $signed(cfg_data);
				lpt_pkg::REG_INIT_WEIGHT_B: cfg_q.init_b    <= $signed(cfg_data);
				lpt_pkg::REG_INIT_BIAS:     cfg_q.init_bias <= $signed(cfg_data);
				lpt_pkg::REG_LEARNING_RATE: cfg_q.rate      <= cfg_data[lpt_pkg::LR_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_word.a      = sample_a;
	assign in_word.b      = sample_b;
	assign in_word.target = target;
	assign in_word.last   = last_sample;

	lpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.take     (q_take),
		.avail    (q_avail),
		.out_word (q_word)
	);

	lpt_back #(
		.FRAC_BITS           (FRAC_BITS),
		.SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.avail     (q_avail),
		.in_word   (q_word),
		.take      (q_take),
		.empty     (empty),
		.pop       (pop),
		.result_id (result_id),
		.weight_a  (weight_a),
		.weight_b  (weight_b),
		.bias      (bias)
	);

endmodule

@@ src/lpt_checker.sv @@
module lpt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              push,
	input logic                              full,
	input logic                              empty,
	input logic                              pop,
	input logic [lpt_pkg::DATA_W-1:0]        result_id,
	input logic signed [lpt_pkg::DATA_W-1:0] weight_a,
	input logic signed [lpt_pkg::DATA_W-1:0] weight_b,
	input logic signed [lpt_pkg::DATA_W-1:0] bias
);

	// held in reset: no result and room for input
	a_reset_state: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queue flags wrong during reset");

	// a waiting result word holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_id) && $stable(weight_a)
			&& $stable(weight_b) && $stable(bias)))
		else $error("result word changed while waiting");

	// the input side only fills up on a push
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// no result can come out sooner than the sequence allows after reset
	a_no_early_result: assert property (@(posedge clk)
		$rose(arst_n) |-> empty ##1 empty ##1 empty ##1 empty)
		else $error("result appeared too early after reset");

endmodule

bind logistic_perceptron_trainer lpt_checker u_lpt_checker (.*);
